// File: sv/sws_pkg.sv
`default_nettype none
package sws_pkg;

  // Sizing of the window store and of the sample datapath.
  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + IDX_W;
  localparam int DCNT_W      = $clog2(SUM_W + 1);

  // Fixed field widths of the ports.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_W      = 32;
  localparam int CNT_W      = 16;
  localparam int WLEN_W     = 5;
  localparam int MINS_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 216;

  localparam int RESET_WLEN = 16;
  localparam int RESET_WIN  = (RESET_WLEN > MAX_WINDOW) ? MAX_WINDOW : RESET_WLEN;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 2'd1;

  // What the store read issued in a cycle is meant for.
  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_OLDEST = 2'd1,
    RD_NEWEST = 2'd2,
    RD_SCAN   = 2'd3
  } rd_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     in_load;
    logic     update;
    rd_kind_e rd;
    logic     scan_start;
    logic     div_start;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stats_ready;
    logic scan_last;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: sv/sws_ram.sv
`default_nettype none
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/sws_ctrl.sv
`default_nettype none
module sws_ctrl
  import sws_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_UPD   = 9'b0_0000_0010,
    ST_RDO   = 9'b0_0000_0100,
    ST_RDN   = 9'b0_0000_1000,
    ST_SCAN  = 9'b0_0001_0000,
    ST_DRAIN = 9'b0_0010_0000,
    ST_PREP  = 9'b0_0100_0000,
    ST_DIV   = 9'b0_1000_0000,
    ST_OUT   = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Sequencing of one word: update, two reads, scan and divide when statistics are ready, deliver.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd   = RD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_RDO;
      end
      ST_RDO: begin
        cmd_o.rd = RD_OLDEST;
        state_d  = ST_RDN;
      end
      ST_RDN: begin
        cmd_o.rd         = RD_NEWEST;
        cmd_o.scan_start = 1'b1;
        state_d          = status_i.stats_ready ? ST_SCAN : ST_DRAIN;
      end
      ST_SCAN: begin
        cmd_o.rd = RD_SCAN;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last read lands on this edge: in the sorting row and sum, else in newest.
        if (status_i.stats_ready) begin
          state_d = ST_PREP;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_PREP: begin
        // Sum and sorted row are complete; load the divider and the median.
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/sws_dpath.sv
`default_nettype none
module sws_dpath
  import sws_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  wire  [IN_DATA_W-1:0]   in_data_i,
  input  wire                    in_clear_i,
  input  wire                    cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [OUT_DATA_W-1:0]  out_data_o
);

  logic [WLEN_W-1:0]             window_len_q;
  logic [MINS_W-1:0]             min_samples_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          clear_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [IDX_W-1:0]              wi_q;
  logic signed [SAMPLE_BITS-1:0] oldest_q, newest_q, median_q;
  rd_kind_e                      rd_kind_q;
  logic [IDX_W-1:0]              scan_idx_q;
  logic [LEN_W-1:0]              ins_n_q;
  logic signed [SAMPLE_BITS-1:0] sorted_q [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] sorted_d [MAX_WINDOW];
  logic signed [SUM_W-1:0]       sum_q;
  logic [SUM_W-1:0]              dq_q;
  logic [LEN_W-1:0]              rem_q;
  logic [DCNT_W-1:0]             dcnt_q;
  logic                          neg_q;
  logic                          out_valid_q;
  logic [OUT_DATA_W-1:0]         out_data_q;

  logic [LEN_W-1:0]              win, len, win_m1;
  logic [IDX_W:0]                wi_inc;
  logic [IDX_W-1:0]              wi_next, oldest_pos, raddr;
  logic                          has, ready;
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic                          gt [MAX_WINDOW];

  // Effective window: zero acts as one, large values clip to the store depth.
  always_comb begin
    if (window_len_q == '0) begin
      win = LEN_W'(1);
    end else if (32'(window_len_q) > 32'(MAX_WINDOW)) begin
      win = LEN_W'(MAX_WINDOW);
    end else begin
      win = LEN_W'(window_len_q);
    end
    win_m1 = win - LEN_W'(1);
  end

  // Ring pointers and window fill.
  always_comb begin
    wi_inc  = {1'b0, wi_q} + 1'b1;
    wi_next = (wi_inc >= win) ? '0 : wi_inc[IDX_W-1:0];
    len     = (cnt_q < win) ? LEN_W'(cnt_q) : win;
    has     = (len != '0);
    ready   = has && (cnt_q >= min_samples_q);
    oldest_pos = (cnt_q >= win) ? wi_next : '0;
    case (cmd_i.rd)
      RD_OLDEST: raddr = oldest_pos;
      RD_NEWEST: raddr = wi_q;
      RD_SCAN:   raddr = scan_idx_q;
      default:   raddr = wi_q;
    endcase
  end

  sws_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update && !clear_q),
    .waddr_i (wi_next),
    .wdata_i (sample_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Insertion of one read sample into the sorted row; larger entries move up.
  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      gt[k] = (k >= int'(ins_n_q)) || (sorted_q[k] > rdata);
    end
    sorted_d[0] = gt[0] ? rdata : sorted_q[0];
    for (int k = 1; k < MAX_WINDOW; k++) begin
      if (!gt[k]) begin
        sorted_d[k] = sorted_q[k];
      end else if (gt[k-1]) begin
        sorted_d[k] = sorted_q[k-1];
      end else begin
        sorted_d[k] = rdata;
      end
    end
  end

  // Median from the sorted row; an even length averages the middle pair.
  logic signed [SAMPLE_BITS-1:0] mid_hi, mid_lo;
  logic signed [SAMPLE_BITS:0]   mid_sum, mid_adj;
  logic signed [SAMPLE_BITS-1:0] median_d;
  always_comb begin
    mid_hi   = sorted_q[IDX_W'(len >> 1)];
    mid_lo   = sorted_q[IDX_W'((len >> 1) - LEN_W'(1))];
    mid_sum  = (SAMPLE_BITS+1)'(mid_hi) + (SAMPLE_BITS+1)'(mid_lo);
    mid_adj  = mid_sum + (SAMPLE_BITS+1)'(mid_sum[SAMPLE_BITS]);
    median_d = len[0] ? mid_hi : SAMPLE_BITS'(mid_adj >>> 1);
  end

  // One restoring division step on the magnitude of the window sum.
  logic [LEN_W:0] rem_sh, rem_sub;
  logic           q_bit;
  always_comb begin
    rem_sh  = {rem_q, dq_q[SUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, len});
    rem_sub = rem_sh - {1'b0, len};
  end

  // Result word assembly.
  logic [SUM_W-1:0]              quot;
  logic signed [SAMPLE_BITS-1:0] avg_s, old_o, new_o, avg_o, med_o, min_o, max_o;
  always_comb begin
    quot  = neg_q ? (-dq_q) : dq_q;
    avg_s = SAMPLE_BITS'(quot);
    old_o = has ? oldest_q : '0;
    new_o = has ? newest_q : '0;
    avg_o = ready ? avg_s : '0;
    med_o = ready ? median_q : '0;
    min_o = ready ? sorted_q[0] : '0;
    max_o = ready ? sorted_q[IDX_W'(win_m1 - (win - len))] : '0;
  end

  // Control registers: configuration, counters, output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q  <= WLEN_W'(RESET_WLEN);
      min_samples_q <= MINS_W'(1);
      cnt_q         <= '0;
      wi_q          <= IDX_W'(RESET_WIN - 1);
      rd_kind_q     <= RD_NONE;
      out_valid_q   <= 1'b0;
    end else begin
      rd_kind_q <= cmd_i.rd;
      if (cfg_we_i && cfg_index_i == REG_WINDOW_LEN) begin
        window_len_q <= cfg_data_i[WLEN_W-1:0];
        cnt_q        <= '0;
        // The history restarts against the newly written window.
        if (cfg_data_i[WLEN_W-1:0] == '0) begin
          wi_q <= '0;
        end else if (32'(cfg_data_i[WLEN_W-1:0]) > 32'(MAX_WINDOW)) begin
          wi_q <= IDX_W'(MAX_WINDOW - 1);
        end else begin
          wi_q <= IDX_W'(cfg_data_i[WLEN_W-1:0] - WLEN_W'(1));
        end
      end else if (cmd_i.update) begin
        if (clear_q) begin
          cnt_q <= '0;
          wi_q  <= IDX_W'(win_m1);
        end else begin
          wi_q <= wi_next;
          if (cnt_q != '1) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
      end
      if (cfg_we_i && cfg_index_i == REG_MIN_SAMPLES) begin
        min_samples_q <= cfg_data_i[MINS_W-1:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      sample_q <= SAMPLE_BITS'(in_data_i);
      clear_q  <= in_clear_i;
    end
    case (rd_kind_q)
      RD_OLDEST: oldest_q <= rdata;
      RD_NEWEST: newest_q <= rdata;
      RD_SCAN: begin
        sorted_q <= sorted_d;
        sum_q    <= sum_q + SUM_W'(rdata);
        ins_n_q  <= ins_n_q + 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd_i.scan_start) begin
      scan_idx_q <= '0;
      ins_n_q    <= '0;
      sum_q      <= '0;
    end else if (cmd_i.rd == RD_SCAN) begin
      scan_idx_q <= scan_idx_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      dq_q     <= sum_q[SUM_W-1] ? (-sum_q) : sum_q;
      neg_q    <= sum_q[SUM_W-1];
      rem_q    <= '0;
      dcnt_q   <= DCNT_W'(SUM_W);
      median_q <= median_d;
    end else if (cmd_i.div_step) begin
      rem_q  <= q_bit ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      dq_q   <= {dq_q[SUM_W-2:0], q_bit};
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {1'b0, OUT_W'(max_o), OUT_W'(min_o), OUT_W'(med_o), OUT_W'(avg_o),
                     OUT_W'(new_o), OUT_W'(old_o), ready, has, WLEN_W'(len), cnt_q};
    end
  end

  assign status_o.stats_ready = ready;
  assign status_o.scan_last   = (32'(scan_idx_q) + 32'd1 >= 32'(len));
  assign status_o.div_done    = (dcnt_q == '0);
  assign status_o.out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_data_q;

endmodule
`default_nettype wire

// File: sv/sliding_window_statistics.sv
// Sliding-window statistics over signed samples. Each input word either clears
// the history (tuser set) or pushes one sample into a 16-entry ring store, and
// every input word yields exactly one result word: saturating sample count,
// filled length, oldest and newest sample, and the truncated mean, median,
// minimum and maximum of the window (zero until the statistics are ready).
// When statistics are ready, the store is scanned one entry a cycle into a
// sorting row, then a one-bit-per-cycle divider forms the mean; otherwise
// both steps are skipped. A finished result waits while an unread result
// holds the output register. One item is in work at a time; the next input
// is taken as soon as the result sits in the output register.
// Configuration writes are always accepted and belong between items; writing
// the window length clears the history.
`default_nettype none
module sliding_window_statistics
  import sws_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire  [IN_DATA_W-1:0]   s_axis_tdata,   // sample
  input  wire  [0:0]             s_axis_tuser,   // clear
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // sample_count, filled_length, has_samples, stats_ready, oldest, newest,
  // average, median, minimum, maximum, then one zero pad bit
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  sws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  sws_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_clear_i  (s_axis_tuser[0]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // A new word is never taken on the cycle right after one was accepted.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous word in work");

  // A result is loaded only into an empty or draining output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load && m_axis_tvalid |-> m_axis_tready)
    else $error("pending result overwritten");

  // Ready statistics imply a non-empty window.
  a_ready_has: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[22] && !m_axis_tdata[21]))
    else $error("statistics ready on an empty window");

endmodule
`default_nettype wire
